// ===== sv/ipc_pkg.sv =====
// Shared constants, types and helper functions for the interferometer phase correction.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package ipc_pkg;

	localparam int NUM_CH     = 4;
	localparam int CH_W       = $clog2(NUM_CH);
	localparam int WINDOW_LEN = 4;
	localparam int FRAC_BITS  = 7;

	localparam int PHASE_W  = 17;
	localparam int FREQ_W   = 16;
	localparam int FREQ_FRAC = 8;
	localparam int FSUM_W   = FREQ_W + FREQ_FRAC + 1;
	localparam int SF_W     = 21;
	localparam int SKEW_W   = 8;
	localparam int OFFSET_W = 17;
	localparam int VAL_W    = 20;
	localparam int DELTA_W  = 20;
	localparam int SUM_W    = DELTA_W + $clog2(WINDOW_LEN);
	localparam int DEG_W    = 12;
	localparam int DEG_MAX  = 2047;
	localparam int DEG_MIN  = -2048;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	localparam int SF_MAX      = 5000 << FREQ_FRAC;
	localparam int SF_FALLBACK = 3000 << FREQ_FRAC;

	// Skew term: f * skew * 360 * 2^7 / (44643 * 8 * 2^8), rounded half away.
	// Reduced to floor(((30 * |f * skew| + 29762) >> 2) / 14881), and the
	// division by 14881 is an exact reciprocal multiply for dividends below 2^31.
	localparam int SKEW_SCALE_W = 34;
	localparam int SKEW_BIAS    = 29762;
	localparam logic [MUL_W-1:0] SKEW_MAGIC = 32'd2364382239;
	localparam int SKEW_SHIFT   = 45;
	localparam int QUO_W        = 17;

	localparam int JUMP  = 150 << FRAC_BITS;
	localparam int CALM  = (20 * WINDOW_LEN) << FRAC_BITS;
	localparam int TENTH = ((1 << FRAC_BITS) + 5) / 10;

	typedef enum logic [2:0] {
		REG_ALPHA_SKEW,
		REG_BETA_SKEW,
		REG_ALPHA_LONG_SKEW,
		REG_BETA_LONG_SKEW,
		REG_ALPHA_OFFSET,
		REG_BETA_OFFSET,
		REG_ALPHA_LONG_OFFSET,
		REG_BETA_LONG_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_CH-1:0][SKEW_W-1:0]   skew;
		logic [NUM_CH-1:0][OFFSET_W-1:0] offset;
	} cfg_t;

	// Round to whole degrees, halves away from zero, then saturate.
	function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [VAL_W-1:0] v);
		logic [VAL_W-1:0]                mag;
		logic [VAL_W-FRAC_BITS:0]        r;
		logic signed [VAL_W-FRAC_BITS+1:0] d;
		mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
		r = (VAL_W-FRAC_BITS+1)'(({1'b0, mag} + (VAL_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
		d = v[VAL_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
		if (d > (VAL_W-FRAC_BITS+2)'(DEG_MAX))
			d = (VAL_W-FRAC_BITS+2)'(DEG_MAX);
		if (d < (VAL_W-FRAC_BITS+2)'(DEG_MIN))
			d = (VAL_W-FRAC_BITS+2)'(DEG_MIN);
		return DEG_W'(d);
	endfunction

endpackage

`default_nettype wire

// ===== sv/ipc_if.sv =====
// Valid/ready channel interfaces for measurement requests and corrected results.
// Depends on ipc_pkg for field widths.
`default_nettype none

interface ipc_meas_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ipc_pkg::PHASE_W-1:0]   alpha_phase;
	logic signed [ipc_pkg::PHASE_W-1:0]   beta_phase;
	logic signed [ipc_pkg::PHASE_W-1:0]   alpha_long_phase;
	logic signed [ipc_pkg::PHASE_W-1:0]   beta_long_phase;
	logic [ipc_pkg::FREQ_W-1:0]           peak_freq;

	modport source(output valid, alpha_phase, beta_phase, alpha_long_phase, beta_long_phase,
		peak_freq, input ready);
	modport sink(input valid, alpha_phase, beta_phase, alpha_long_phase, beta_long_phase,
		peak_freq, output ready);
endinterface

interface ipc_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [ipc_pkg::DEG_W-1:0]   alpha_deg;
	logic signed [ipc_pkg::DEG_W-1:0]   beta_deg;
	logic signed [ipc_pkg::DEG_W-1:0]   alpha_long_deg;
	logic signed [ipc_pkg::DEG_W-1:0]   beta_long_deg;

	modport source(output valid, alpha_deg, beta_deg, alpha_long_deg, beta_long_deg,
		input ready);
	modport sink(input valid, alpha_deg, beta_deg, alpha_long_deg, beta_long_deg,
		output ready);
endinterface

`default_nettype wire

// ===== sv/ipc_cfg.sv =====
// APB register file holding the skew and offset settings of the four baselines.
// Depends on ipc_pkg.
`default_nettype none

module ipc_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ipc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ipc_pkg::DATA_W-1:0]   pwdata,
	output logic      [ipc_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output ipc_pkg::cfg_t                     cfg
);

	ipc_pkg::cfg_t     cfg_q;
	ipc_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = ipc_pkg::reg_idx_t'(paddr[ipc_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				ipc_pkg::REG_ALPHA_SKEW:        cfg_q.skew[0] <= {pwdata[6], pwdata[6:0]};
				ipc_pkg::REG_BETA_SKEW:         cfg_q.skew[1] <= {pwdata[6], pwdata[6:0]};
				ipc_pkg::REG_ALPHA_LONG_SKEW:   cfg_q.skew[2] <= pwdata[7:0];
				ipc_pkg::REG_BETA_LONG_SKEW:    cfg_q.skew[3] <= pwdata[7:0];
				ipc_pkg::REG_ALPHA_OFFSET:      cfg_q.offset[0] <= pwdata[16:0];
				ipc_pkg::REG_BETA_OFFSET:       cfg_q.offset[1] <= pwdata[16:0];
				ipc_pkg::REG_ALPHA_LONG_OFFSET: cfg_q.offset[2] <= pwdata[16:0];
				ipc_pkg::REG_BETA_LONG_OFFSET:  cfg_q.offset[3] <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ipc_pkg::REG_ALPHA_SKEW:        prdata = {{24{cfg_q.skew[0][7]}}, cfg_q.skew[0]};
			ipc_pkg::REG_BETA_SKEW:         prdata = {{24{cfg_q.skew[1][7]}}, cfg_q.skew[1]};
			ipc_pkg::REG_ALPHA_LONG_SKEW:   prdata = {{24{cfg_q.skew[2][7]}}, cfg_q.skew[2]};
			ipc_pkg::REG_BETA_LONG_SKEW:    prdata = {{24{cfg_q.skew[3][7]}}, cfg_q.skew[3]};
			ipc_pkg::REG_ALPHA_OFFSET:      prdata = {{15{cfg_q.offset[0][16]}}, cfg_q.offset[0]};
			ipc_pkg::REG_BETA_OFFSET:       prdata = {{15{cfg_q.offset[1][16]}}, cfg_q.offset[1]};
			ipc_pkg::REG_ALPHA_LONG_OFFSET: prdata = {{15{cfg_q.offset[2][16]}}, cfg_q.offset[2]};
			ipc_pkg::REG_BETA_LONG_OFFSET:  prdata = {{15{cfg_q.offset[3][16]}}, cfg_q.offset[3]};
			default:                        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/ipc_mul.sv =====
// Shared unsigned multiplier with a registered product, reused for every skew term.
// Depends on ipc_pkg.
`default_nettype none

module ipc_mul (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [ipc_pkg::MUL_W-1:0]    a,
	input  wire logic [ipc_pkg::MUL_W-1:0]    b,
	output logic      [ipc_pkg::PROD_W-1:0]   prod
);

	logic [ipc_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en)
			prod_q <= ipc_pkg::PROD_W'(a) * ipc_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ===== sv/ipc_restore.sv =====
// Sign restore for one short baseline: previous phase and window of magnitude changes.
// Depends on ipc_pkg.
`default_nettype none

module ipc_restore (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               upd,
	input  wire logic signed [ipc_pkg::VAL_W-1:0]   v,
	output logic signed      [ipc_pkg::VAL_W-1:0]   res
);

	logic signed [ipc_pkg::VAL_W-1:0]   prev_q;
	logic signed [ipc_pkg::DELTA_W-1:0] win_q [ipc_pkg::WINDOW_LEN];
	logic signed [ipc_pkg::SUM_W-1:0]   sum;
	logic [ipc_pkg::SUM_W-1:0]          abs_sum;
	logic signed [ipc_pkg::VAL_W:0]     diff;
	logic [ipc_pkg::VAL_W:0]            abs_diff;
	logic [ipc_pkg::VAL_W-1:0]          abs_v;
	logic [ipc_pkg::VAL_W-1:0]          abs_prev;
	logic                               flip;
	logic signed [ipc_pkg::DELTA_W-1:0] delta;

	always_comb begin
		sum = '0;
		for (int i = 0; i < ipc_pkg::WINDOW_LEN; i++)
			sum = sum + ipc_pkg::SUM_W'(win_q[i]);
	end

	assign abs_sum  = sum[ipc_pkg::SUM_W-1] ? ipc_pkg::SUM_W'(-sum) : ipc_pkg::SUM_W'(sum);
	assign diff     = {v[ipc_pkg::VAL_W-1], v} - {prev_q[ipc_pkg::VAL_W-1], prev_q};
	assign abs_diff = diff[ipc_pkg::VAL_W] ? (ipc_pkg::VAL_W+1)'(-diff)
		: (ipc_pkg::VAL_W+1)'(diff);
	assign abs_v    = v[ipc_pkg::VAL_W-1] ? ipc_pkg::VAL_W'(-v) : ipc_pkg::VAL_W'(v);
	assign abs_prev = prev_q[ipc_pkg::VAL_W-1] ? ipc_pkg::VAL_W'(-prev_q)
		: ipc_pkg::VAL_W'(prev_q);

	assign flip = (abs_sum < ipc_pkg::SUM_W'(ipc_pkg::CALM))
		&& (abs_diff > (ipc_pkg::VAL_W+1)'(ipc_pkg::JUMP))
		&& (abs_v > ipc_pkg::VAL_W'(ipc_pkg::JUMP));

	// Take the sign of the previous sample: positive only if it was above zero.
	assign res = !flip ? v
		: (prev_q > 0) ? $signed(abs_v) : -$signed(abs_v);

	assign delta = ipc_pkg::DELTA_W'({1'b0, abs_v} - {1'b0, abs_prev});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int i = 0; i < ipc_pkg::WINDOW_LEN; i++)
				win_q[i] <= ipc_pkg::DELTA_W'(ipc_pkg::TENTH);
		end else if (upd) begin
			prev_q <= res;
			for (int i = 0; i < ipc_pkg::WINDOW_LEN - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[ipc_pkg::WINDOW_LEN-1] <= delta;
		end
	end

endmodule

`default_nettype wire

// ===== sv/interferometer_phase_correction.sv =====
// Interferometer phase correction: an accepted measurement request smooths the peak
// frequency, adds a skew term and an offset to each of the four phases, restores the
// sign of the short-baseline phases after a false flip and returns the four phases in
// whole degrees. One shared multiplier forms each skew term in two passes (frequency
// times skew, then an exact reciprocal multiply for the constant divisor); each
// baseline steps through S_MUL_P, S_MUL_Y and S_ACC in turn. The next request is taken
// only once the result is loaded, which waits while the output register is still full.
// The user must write settings over APB while the block is idle; the block does not check.
// Depends on ipc_pkg, ipc_if, ipc_cfg, ipc_mul and ipc_restore.
`default_nettype none

module interferometer_phase_correction (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	ipc_meas_if.sink                          meas,
	ipc_res_if.source                         corr,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ipc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ipc_pkg::DATA_W-1:0]   pwdata,
	output logic      [ipc_pkg::DATA_W-1:0]   prdata,
	output logic                              pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_Y,
		S_ACC,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic [ipc_pkg::CH_W-1:0]           ch_q;
	logic [ipc_pkg::SF_W-1:0]           sf_q;
	logic                               out_valid_q;

	logic signed [ipc_pkg::PHASE_W-1:0] phase_q [ipc_pkg::NUM_CH];
	logic signed [ipc_pkg::VAL_W-1:0]   v_q [ipc_pkg::NUM_CH];
	logic signed [ipc_pkg::DEG_W-1:0]   alpha_deg_q;
	logic signed [ipc_pkg::DEG_W-1:0]   beta_deg_q;
	logic signed [ipc_pkg::DEG_W-1:0]   alpha_long_deg_q;
	logic signed [ipc_pkg::DEG_W-1:0]   beta_long_deg_q;

	ipc_pkg::cfg_t                      cfg;
	logic                               accept;
	logic                               load;
	logic [ipc_pkg::FSUM_W-1:0]         fsum;
	logic [ipc_pkg::FSUM_W-2:0]         fhalf;
	logic [ipc_pkg::SF_W-1:0]           sf_next;

	logic signed [ipc_pkg::SKEW_W-1:0]  skew;
	logic [ipc_pkg::SKEW_W-1:0]         skew_mag;
	logic [ipc_pkg::SKEW_SCALE_W-1:0]   p_ext;
	logic [ipc_pkg::SKEW_SCALE_W-1:0]   scaled;
	logic [ipc_pkg::MUL_W-1:0]          y;
	logic [ipc_pkg::QUO_W-1:0]          quo;
	logic signed [ipc_pkg::VAL_W-1:0]   skew_corr;
	logic signed [ipc_pkg::VAL_W-1:0]   v_acc;

	logic                               mul_en;
	logic [ipc_pkg::MUL_W-1:0]          mul_a;
	logic [ipc_pkg::MUL_W-1:0]          mul_b;
	logic [ipc_pkg::PROD_W-1:0]         prod;

	logic signed [ipc_pkg::VAL_W-1:0]   alpha_res;
	logic signed [ipc_pkg::VAL_W-1:0]   beta_res;

	ipc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipc_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ipc_restore u_restore_alpha (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (load),
		.v      (v_q[0]),
		.res    (alpha_res)
	);

	ipc_restore u_restore_beta (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (load),
		.v      (v_q[1]),
		.res    (beta_res)
	);

	assign meas.ready = (state_q == S_IDLE);
	assign accept     = meas.valid && meas.ready;
	assign load       = (state_q == S_DONE) && (!out_valid_q || corr.ready);

	// Move halfway toward the new peak; fall back when out of range.
	assign fsum    = ipc_pkg::FSUM_W'(sf_q) + ipc_pkg::FSUM_W'({meas.peak_freq,
		{ipc_pkg::FREQ_FRAC{1'b0}}});
	assign fhalf   = fsum[ipc_pkg::FSUM_W-1:1];
	assign sf_next = (fhalf > (ipc_pkg::FSUM_W-1)'(ipc_pkg::SF_MAX))
		? ipc_pkg::SF_W'(ipc_pkg::SF_FALLBACK) : ipc_pkg::SF_W'(fhalf);

	assign skew     = $signed(cfg.skew[ch_q]);
	assign skew_mag = skew[ipc_pkg::SKEW_W-1] ? ipc_pkg::SKEW_W'(-skew) : ipc_pkg::SKEW_W'(skew);

	// Magnitude of f * skew is in the low bits of the product after the first pass.
	assign p_ext  = ipc_pkg::SKEW_SCALE_W'(prod[ipc_pkg::SF_W+ipc_pkg::SKEW_W-1:0]);
	assign scaled = (p_ext << 5) - (p_ext << 1) + ipc_pkg::SKEW_SCALE_W'(ipc_pkg::SKEW_BIAS);
	assign y      = scaled[ipc_pkg::SKEW_SCALE_W-1:2];

	assign quo       = prod[ipc_pkg::SKEW_SHIFT+ipc_pkg::QUO_W-1:ipc_pkg::SKEW_SHIFT];
	assign skew_corr = skew[ipc_pkg::SKEW_W-1] ? -$signed(ipc_pkg::VAL_W'(quo))
		: $signed(ipc_pkg::VAL_W'(quo));
	assign v_acc = ipc_pkg::VAL_W'(phase_q[ch_q]) + skew_corr
		+ ipc_pkg::VAL_W'($signed(cfg.offset[ch_q]));

	always_comb begin
		mul_en = 1'b0;
		mul_a  = ipc_pkg::MUL_W'(sf_q);
		mul_b  = ipc_pkg::MUL_W'(skew_mag);
		case (state_q)
			S_MUL_P: begin
				mul_en = 1'b1;
			end
			S_MUL_Y: begin
				mul_en = 1'b1;
				mul_a  = y;
				mul_b  = ipc_pkg::SKEW_MAGIC;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			sf_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (corr.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (meas.valid) begin
						sf_q    <= sf_next;
						ch_q    <= '0;
						state_q <= S_MUL_P;
					end
				end
				S_MUL_P: begin
					state_q <= S_MUL_Y;
				end
				S_MUL_Y: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (ch_q == ipc_pkg::CH_W'(ipc_pkg::NUM_CH - 1)) begin
						state_q <= S_DONE;
					end else begin
						ch_q    <= ch_q + ipc_pkg::CH_W'(1);
						state_q <= S_MUL_P;
					end
				end
				S_DONE: begin
					if (load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q[0] <= meas.alpha_phase;
			phase_q[1] <= meas.beta_phase;
			phase_q[2] <= meas.alpha_long_phase;
			phase_q[3] <= meas.beta_long_phase;
		end
		if (state_q == S_ACC)
			v_q[ch_q] <= v_acc;
		if (load) begin
			alpha_deg_q      <= ipc_pkg::to_deg(alpha_res);
			beta_deg_q       <= ipc_pkg::to_deg(beta_res);
			alpha_long_deg_q <= ipc_pkg::to_deg(v_q[2]);
			beta_long_deg_q  <= ipc_pkg::to_deg(v_q[3]);
		end
	end

	assign corr.valid          = out_valid_q;
	assign corr.alpha_deg      = alpha_deg_q;
	assign corr.beta_deg       = beta_deg_q;
	assign corr.alpha_long_deg = alpha_long_deg_q;
	assign corr.beta_long_deg  = beta_long_deg_q;

endmodule

`default_nettype wire
